// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define NPA_ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("npa assertion failed");

// Assertion on aclk / aresetn.
`define NPA_ASSERT(lbl, prop) `NPA_ASSERT_AT(lbl, aclk, aresetn, prop)

`endif

// ===== src/npa_pkg.sv =====
// ----------------------------------------------------------------------------
// npa_pkg
// Shared widths, opcodes and constants of the number pool allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package npa_pkg;

    localparam int DEFAULT_CAPACITY = 256;
    localparam int ID_LIMIT         = 256;

    localparam int OP_W      = 2;
    localparam int ID_W      = 8;
    localparam int GRANT_W   = 9;
    localparam int TOTAL_W   = 9;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [OP_W-1:0] OP_GET     = 2'd0;
    localparam logic [OP_W-1:0] OP_CHECK   = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    localparam logic [GRANT_W-1:0] GRANT_NONE = 9'h1FF;

    // m_tdata bit positions
    localparam int M_FREE_BIT = GRANT_W;
    localparam int M_ACC_BIT  = GRANT_W + 1;

endpackage

`default_nettype wire

// ===== src/number_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// number_pool_allocator_unit
// Identifier pool on a LIFO free stack in synchronous RAM plus a held bitmap RAM.
// ----------------------------------------------------------------------------
// Each request has an accept cycle and an execute cycle. The accept cycle
// issues the stack read at the top-of-stack address and the bitmap read at
// the request number. The execute cycle writes back the stack RAM and the
// held bitmap RAM and loads the result register. s_tready is low in that
// cycle and stays low while the result register is still occupied, so a new
// request is taken only after the last one is done. After reset and after
// each cfg write of total_numbers, the held bitmap RAM is cleared one entry
// per cycle, all DEPTH entries (256 by default), with s_tready low. The stack
// needs no fill: slots below the lowest fill level seen since the restart read
// as their own index. Effective pool size is min(total_numbers, CAPACITY, 256).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module number_pool_allocator_unit #(
    parameter int CAPACITY = npa_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [npa_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] number
    input  wire logic [npa_pkg::OP_W-1:0]      s_tuser,   // [1:0] opcode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [8:0] granted_number, [9] is_free, [10] release_accepted, [15:11] zero
    output logic [npa_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [npa_pkg::TOTAL_W-1:0]   cfg_wr_data
);
    import npa_pkg::*;

    localparam int DEPTH   = (CAPACITY < ID_LIMIT) ? CAPACITY : ID_LIMIT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_t;

    state_t               state_reg,  state_next;
    logic [COUNT_W-1:0]   count_reg,  count_next;
    logic [COUNT_W-1:0]   low_reg,    low_next;
    logic [ADDR_W-1:0]    clr_reg,    clr_next;
    logic [OP_W-1:0]      op_reg;
    logic [ID_W-1:0]      num_reg;
    logic [ADDR_W-1:0]    idx_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [GRANT_W-1:0]   grant_reg,  grant_next;
    logic                 free_reg,   free_next;
    logic                 acc_reg,    acc_next;

    logic [ID_W-1:0]      stack_mem [DEPTH];
    logic [ID_W-1:0]      rd_data_reg;
    logic                 held_mem [DEPTH];
    logic                 held_rd_reg;

    logic                 s_acc;
    logic [COUNT_W-1:0]   count_dec;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 finish;
    logic                 pop_ok;
    logic [ID_W-1:0]      pop_id;
    logic                 in_pool;
    logic                 held_bit;
    logic                 push_ok;
    logic                 wr_en;
    logic                 get_wr;
    logic                 held_we;
    logic [ADDR_W-1:0]    held_waddr;
    logic                 held_wdata;
    logic [COUNT_W-1:0]   cfg_size;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign count_dec = count_reg - COUNT_W'(1);
    assign rd_addr   = count_dec[ADDR_W-1:0];
    assign finish    = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    assign pop_ok   = (count_reg != '0);
    assign pop_id   = (COUNT_W'(idx_reg) >= low_reg) ? rd_data_reg : ID_W'(idx_reg);
    assign in_pool  = ({1'b0, num_reg} < TOTAL_W'(DEPTH));
    assign held_bit = in_pool && held_rd_reg;
    assign push_ok  = held_bit && (count_reg < COUNT_W'(DEPTH));
    assign wr_en    = finish && (op_reg == OP_RELEASE) && push_ok;
    assign get_wr   = finish && (op_reg == OP_GET) && pop_ok;

    assign held_we    = (state_reg == ST_CLEAR) || get_wr || wr_en;
    assign held_waddr = (state_reg == ST_CLEAR) ? clr_reg
                      : get_wr ? pop_id[ADDR_W-1:0] : num_reg[ADDR_W-1:0];
    assign held_wdata = get_wr;

    assign cfg_size = (cfg_wr_data > TOTAL_W'(DEPTH)) ? COUNT_W'(DEPTH)
                                                      : COUNT_W'(cfg_wr_data);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        low_next       = low_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        grant_next     = grant_reg;
        free_next      = free_reg;
        acc_next       = acc_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (finish) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    grant_next     = GRANT_NONE;
                    free_next      = 1'b0;
                    acc_next       = 1'b0;
                    case (op_reg)
                        OP_GET: begin
                            if (pop_ok) begin
                                count_next = count_dec;
                                if (count_dec < low_reg) begin
                                    low_next = count_dec;
                                end
                                grant_next = {1'b0, pop_id};
                            end
                        end
                        OP_CHECK: begin
                            free_next = !held_bit;
                        end
                        OP_RELEASE: begin
                            if (push_ok) begin
                                count_next = count_reg + COUNT_W'(1);
                                acc_next = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        endcase

        if (cfg_wr_en) begin
            state_next = ST_CLEAR;
            clr_next   = '0;
            count_next = cfg_size;
            low_next   = cfg_size;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            count_reg     <= COUNT_W'(DEPTH);
            low_reg       <= COUNT_W'(DEPTH);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            low_reg       <= low_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
        if (s_acc) begin
            op_reg  <= s_tuser;
            num_reg <= s_tdata[ID_W-1:0];
            idx_reg <= rd_addr;
        end
        grant_reg <= grant_next;
        free_reg  <= free_next;
        acc_reg   <= acc_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[count_reg[ADDR_W-1:0]] <= num_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (held_we) begin
            held_mem[held_waddr] <= held_wdata;
        end
        if (s_acc) begin
            held_rd_reg <= held_mem[s_tdata[ADDR_W-1:0]];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - GRANT_W - 2){1'b0}}, acc_reg, free_reg, grant_reg};

endmodule

`default_nettype wire

// ===== src/npa_checker.sv =====
// ----------------------------------------------------------------------------
// npa_checker
// Port-level checks of the number pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module npa_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [npa_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] number
    input wire logic [npa_pkg::OP_W-1:0]      s_tuser,   // [1:0] opcode
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    // [8:0] granted_number, [9] is_free, [10] release_accepted
    input wire logic [npa_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          cfg_wr_en,
    input wire logic [npa_pkg::TOTAL_W-1:0]   cfg_wr_data
);
    import npa_pkg::*;

    logic s_acc;
    logic flag_set;
    logic unused_ok;

    assign s_acc     = s_tvalid && s_tready;
    assign flag_set  = m_tdata[M_FREE_BIT] || m_tdata[M_ACC_BIT];
    assign unused_ok = ^{s_tdata, s_tuser, cfg_wr_en, cfg_wr_data} || 1'b1;

    // stalled result holds
    `NPA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // no accept right after an accept
    `NPA_ASSERT(a_one_inflight, s_acc && unused_ok |=> !s_tready)
    // a new result only follows the execute cycle
    `NPA_ASSERT(a_result_source, $rose(m_tvalid) |-> !$past(s_tready))
    // check and release answers carry no grant
    `NPA_ASSERT(a_flag_no_grant, m_tvalid && flag_set |-> m_tdata[GRANT_W-1:0] == GRANT_NONE)

endmodule

bind number_pool_allocator_unit npa_checker u_npa_checker (.*);

`default_nettype wire
